// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle outside reset.
`define RMQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rmq assertion failed");

// Implication checked from one cycle into the next.
`define RMQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

`endif

// ----- rtl/rmq_pkg.sv -----
`timescale 1ns / 1ps
package rmq_pkg;

  localparam int unsigned SqrtBits = 17;
  localparam int unsigned QuoBits  = 16;
  localparam logic signed [18:0] QOne = 19'sd16384;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic [1:0]         branch_taken;
  } out_t;

  // Item moving through the square root cells.
  typedef struct packed {
    logic                   vld;
    branch_e                br;
    logic [2:0][16:0]       num;
    logic [33:0]            rem;
    logic [SqrtBits-1:0]    root;
  } sq_t;

  // Item moving through the divider cells.
  typedef struct packed {
    logic                   vld;
    branch_e                br;
    logic [SqrtBits-1:0]    s;
    logic [15:0]            quarter;
    logic [2:0]             neg;
    logic [2:0]             ovf;
    logic [2:0][31:0]       rem;
    logic [2:0][QuoBits-1:0] quo;
  } dv_t;

endpackage

// ----- rtl/rmq_if.sv -----
`timescale 1ns / 1ps
interface rmq_in_if;
  logic         valid;
  logic         ready;
  rmq_pkg::in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmq_out_if;
  logic          valid;
  logic          ready;
  rmq_pkg::out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rmq_sqrt_cell.sv -----
`timescale 1ns / 1ps
module rmq_sqrt_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  rmq_pkg::sq_t sq_i,
  output rmq_pkg::sq_t sq_o
);

  logic [34:0] delta;
  rmq_pkg::sq_t sq_d, sq_q;

  // Try to set this root bit: (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b).
  always_comb begin
    delta = ({18'd0, sq_i.root} << (BIT + 1)) + (35'd1 << (2 * BIT));
    sq_d  = sq_i;
    if ({1'b0, sq_i.rem} >= delta) begin
      sq_d.rem  = sq_i.rem - delta[33:0];
      sq_d.root = sq_i.root | (17'd1 << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= '0;
    end else if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// ----- rtl/rmq_div_cell.sv -----
`timescale 1ns / 1ps
module rmq_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  rmq_pkg::dv_t dv_i,
  output rmq_pkg::dv_t dv_o
);

  logic [32:0] dsh;
  rmq_pkg::dv_t dv_d, dv_q;

  // One restoring quotient bit for each of the three lanes.
  always_comb begin
    dsh  = {16'd0, dv_i.s} << BIT;
    dv_d = dv_i;
    for (int l = 0; l < 3; l++) begin
      if ({1'b0, dv_i.rem[l]} >= dsh) begin
        dv_d.rem[l] = dv_i.rem[l] - dsh[31:0];
        dv_d.quo[l] = dv_i.quo[l] | (16'd1 << BIT);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

// ----- rtl/rotation_matrix_to_quaternion_top.sv -----
`timescale 1ns / 1ps
// Path: front register, root cells, divider setup, divider cells, output register.
// Throughput: one item per cycle; a chain of 17 square root cells and 16 divider
// cells each take one item per cycle, and the whole chain halts while a result waits.
// Reset: asynchronous, active low; clears every valid flag and the output register.
`include "assert_macros.svh"
module rotation_matrix_to_quaternion_top (
  input logic      clk_i,
  input logic      rst_ni,
  rmq_in_if.sink   in_i,
  rmq_out_if.source out_o
);

  logic en;
  rmq_pkg::sq_t sq_q;
  rmq_pkg::sq_t sq_d;
  rmq_pkg::sq_t sq_chain [rmq_pkg::SqrtBits+1];
  rmq_pkg::dv_t dv_q;
  rmq_pkg::dv_t dv_d;
  rmq_pkg::dv_t dv_chain [rmq_pkg::QuoBits+1];
  logic          out_vld_q;
  rmq_pkg::out_t out_q, out_d;

  logic signed [17:0] tr;
  logic signed [18:0] a;
  logic signed [16:0] d_21_12, d_02_20, d_10_01, s_01_10, s_02_20, s_12_21;

  // The chain moves when the output register is free or being emptied.
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // Front stage: pick the branch, form the root argument and the numerators.
  always_comb begin
    tr = 18'(in_i.data.r00) + 18'(in_i.data.r11) + 18'(in_i.data.r22);
    d_21_12 = 17'(in_i.data.r21) - 17'(in_i.data.r12);
    d_02_20 = 17'(in_i.data.r02) - 17'(in_i.data.r20);
    d_10_01 = 17'(in_i.data.r10) - 17'(in_i.data.r01);
    s_01_10 = 17'(in_i.data.r01) + 17'(in_i.data.r10);
    s_02_20 = 17'(in_i.data.r02) + 17'(in_i.data.r20);
    s_12_21 = 17'(in_i.data.r12) + 17'(in_i.data.r21);
    sq_d      = '0;
    sq_d.vld  = in_i.valid;
    if (tr > 18'sd0) begin
      sq_d.br  = rmq_pkg::BR_TRACE;
      a        = rmq_pkg::QOne + 19'(tr);
      sq_d.num = {d_10_01, d_02_20, d_21_12};
    end else if (in_i.data.r00 > in_i.data.r11 && in_i.data.r00 > in_i.data.r22) begin
      sq_d.br  = rmq_pkg::BR_X;
      a        = rmq_pkg::QOne + 19'(in_i.data.r00) - 19'(in_i.data.r11)
                 - 19'(in_i.data.r22);
      sq_d.num = {s_02_20, s_01_10, d_21_12};
    end else if (in_i.data.r11 > in_i.data.r22) begin
      sq_d.br  = rmq_pkg::BR_Y;
      a        = rmq_pkg::QOne + 19'(in_i.data.r11) - 19'(in_i.data.r00)
                 - 19'(in_i.data.r22);
      sq_d.num = {s_12_21, s_01_10, d_02_20};
    end else begin
      sq_d.br  = rmq_pkg::BR_Z;
      a        = rmq_pkg::QOne + 19'(in_i.data.r22) - 19'(in_i.data.r00)
                 - 19'(in_i.data.r11);
      sq_d.num = {s_12_21, s_02_20, d_10_01};
    end
    if (a < 19'sd1) begin
      a = 19'sd1;
    end
    sq_d.rem = {1'b0, a[16:0], 16'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= '0;
    end else if (en) begin
      sq_q <= sq_d;
    end
  end

  // Square root chain, one root bit per cell from the top bit down.
  assign sq_chain[0] = sq_q;
  for (genvar k = 0; k < rmq_pkg::SqrtBits; k++) begin : g_sqrt
    rmq_sqrt_cell #(.BIT(rmq_pkg::SqrtBits - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sq_i   (sq_chain[k]),
      .sq_o   (sq_chain[k+1])
    );
  end

  // Divider setup: rounded quarter of S, magnitudes, and overflow flags.
  always_comb begin
    logic [17:0] mag;
    logic [31:0] nn;
    dv_d         = '0;
    dv_d.vld     = sq_chain[rmq_pkg::SqrtBits].vld;
    dv_d.br      = sq_chain[rmq_pkg::SqrtBits].br;
    dv_d.s       = sq_chain[rmq_pkg::SqrtBits].root;
    dv_d.quarter = 16'((18'(dv_d.s) + 18'd2) >> 2);
    if (dv_d.quarter > 16'd32767) begin
      dv_d.quarter = 16'd32767;
    end
    for (int l = 0; l < 3; l++) begin
      dv_d.neg[l] = sq_chain[rmq_pkg::SqrtBits].num[l][16];
      mag = dv_d.neg[l] ? 18'd0 - {1'b1, sq_chain[rmq_pkg::SqrtBits].num[l]}
                        : {1'b0, sq_chain[rmq_pkg::SqrtBits].num[l]};
      nn  = {mag[17:0], 14'd0} + 32'(dv_d.s >> 1);
      dv_d.rem[l] = nn;
      dv_d.ovf[l] = {1'b0, nn[31:16]} >= dv_d.s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (en) begin
      dv_q <= dv_d;
    end
  end

  // Divider chain, one quotient bit per cell for all three lanes.
  assign dv_chain[0] = dv_q;
  for (genvar k = 0; k < rmq_pkg::QuoBits; k++) begin : g_div
    rmq_div_cell #(.BIT(rmq_pkg::QuoBits - 1 - k)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .dv_i   (dv_chain[k]),
      .dv_o   (dv_chain[k+1])
    );
  end

  // Output stage: saturate the quotients and place them by branch.
  always_comb begin
    logic [2:0][15:0] lane;
    rmq_pkg::dv_t     dl;
    dl = dv_chain[rmq_pkg::QuoBits];
    for (int l = 0; l < 3; l++) begin
      if (dl.neg[l]) begin
        lane[l] = (dl.ovf[l] || dl.quo[l] > 16'd32768) ? 16'h8000 : 16'd0 - dl.quo[l];
      end else begin
        lane[l] = (dl.ovf[l] || dl.quo[l] > 16'd32767) ? 16'h7fff : dl.quo[l];
      end
    end
    out_d.branch_taken = dl.br;
    case (dl.br)
      rmq_pkg::BR_TRACE: begin
        out_d.quat_w = dl.quarter;
        out_d.quat_x = lane[0];
        out_d.quat_y = lane[1];
        out_d.quat_z = lane[2];
      end
      rmq_pkg::BR_X: begin
        out_d.quat_w = lane[0];
        out_d.quat_x = dl.quarter;
        out_d.quat_y = lane[1];
        out_d.quat_z = lane[2];
      end
      rmq_pkg::BR_Y: begin
        out_d.quat_w = lane[0];
        out_d.quat_x = lane[1];
        out_d.quat_y = dl.quarter;
        out_d.quat_z = lane[2];
      end
      default: begin
        out_d.quat_w = lane[0];
        out_d.quat_x = lane[1];
        out_d.quat_y = lane[2];
        out_d.quat_z = dl.quarter;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else if (en) begin
      out_vld_q <= dv_chain[rmq_pkg::QuoBits].vld;
      out_q     <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // The guarded root argument is at least one, so S never drops below 256.
  `RMQ_ASSERT(a_root_min, clk_i, rst_ni,
    !sq_chain[rmq_pkg::SqrtBits].vld || sq_chain[rmq_pkg::SqrtBits].root >= 17'd256)
  // With a positive trace, w is a root component and cannot be negative.
  `RMQ_ASSERT(a_w_pos, clk_i, rst_ni,
    !(out_vld_q && out_q.branch_taken == rmq_pkg::BR_TRACE) || !out_q.quat_w[15])
  // A halted chain keeps its items in place.
  `RMQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, !en, $stable(dv_q) && $stable(sq_q))

endmodule
